>>> src/cpf_pkg.sv
// cpf_pkg: shared constants, payload structs, control types for the coprime pair finder.
// Used by cpf_cell, cpf_ctrl, coprime_pair_finder, cpf_checker and testbench.
// No dependencies.
package cpf_pkg;

	// Table geometry
	localparam int MAX_ELEMENTS = 64;
	localparam int VALUE_BITS   = 8;
	localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	// Binary GCD: each subtract is followed by a shift, so total operand
	// length drops by one at least every two steps.
	localparam int GCD_STEPS = 4 * VALUE_BITS + 4;
	localparam int STEP_W    = $clog2(GCD_STEPS + 1);

	// Input request
	typedef struct packed {
		logic [7:0] value;
		logic       first;
	} cpf_in_t;

	// Result request
	typedef struct packed {
		logic [7:0] earlier_value;
		logic [5:0] earlier_index;
		logic [7:0] new_value;
		logic [5:0] new_index;
		logic       last;
	} cpf_out_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GCD,
		ST_DRAIN
	} cpf_state_t;

	// Commands broadcast to the cell row
	typedef struct packed {
		logic wr;     // store the new element in the selected cell
		logic start;  // load GCD operands
		logic step;   // one binary GCD step
		logic latch;  // capture the coprime flag, load the drain carrier
		logic shift;  // move carriers one cell toward the head
		logic emit;   // head cell holds a pair to send out
	} cpf_cmd_t;

	// Status of the head of the row
	typedef struct packed {
		logic hit;   // head cell holds a coprime pair
		logic more;  // some cell behind the head still holds one
	} cpf_head_t;

endpackage

>>> src/cpf_cell.sv
// cpf_cell: one table entry with its own binary GCD unit and a drain carrier.
// Depends on cpf_pkg.
module cpf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpf_pkg::cpf_cmd_t            cmd,
	input  logic                         wr_sel,
	input  logic                         part,
	input  logic [cpf_pkg::VALUE_BITS-1:0] new_val,
	input  logic [cpf_pkg::VALUE_BITS-1:0] carry_in,
	input  logic                         hit_in,
	output logic [cpf_pkg::VALUE_BITS-1:0] carry,
	output logic                         hit
);

	logic [cpf_pkg::VALUE_BITS-1:0] elem_q;
	logic [cpf_pkg::VALUE_BITS-1:0] a_q;
	logic [cpf_pkg::VALUE_BITS-1:0] b_q;
	logic                           ok_q;
	logic                           hit_q;
	logic                           gcd_one;

	// Stored element
	always_ff @(posedge clk) begin
		if (cmd.wr && wr_sel) begin
			elem_q <= new_val;
		end
	end

	// One operand is zero once done, so the GCD is the OR of both
	assign gcd_one = ((a_q | b_q) == cpf_pkg::VALUE_BITS'(1));

	// GCD operands, reused as the drain carrier
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q  <= elem_q;
			b_q  <= new_val;
			// both even means a factor of two in common
			ok_q <= part && (elem_q[0] || new_val[0]);
		end else if (cmd.step) begin
			if (a_q != '0 && b_q != '0) begin
				if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
		end else if (cmd.latch) begin
			a_q <= elem_q;
		end else if (cmd.shift) begin
			a_q <= carry_in;
		end
	end

	// Coprime flag travels with the carrier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.latch) begin
			hit_q <= ok_q && gcd_one;
		end else if (cmd.shift) begin
			hit_q <= hit_in;
		end
	end

	assign carry = a_q;
	assign hit   = hit_q;

endmodule

>>> src/cpf_ctrl.sv
// cpf_ctrl: sequencer for store, GCD and drain phases; element count and positions.
// Depends on cpf_pkg.
module cpf_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      elem_valid,
	input  logic                      elem_first,
	output logic                      elem_ready,
	input  cpf_pkg::cpf_head_t        head,
	input  logic                      out_busy,
	output cpf_pkg::cpf_cmd_t         cmd,
	output logic [cpf_pkg::IDX_W-1:0] wr_pos,
	output logic [cpf_pkg::IDX_W-1:0] pair_pos,
	output logic [cpf_pkg::IDX_W-1:0] pair_idx
);

	cpf_pkg::cpf_state_t         state_q;
	cpf_pkg::cpf_state_t         state_d;
	logic [cpf_pkg::CNT_W-1:0]   count_q;
	logic [cpf_pkg::IDX_W-1:0]   pos_q;
	logic [cpf_pkg::IDX_W-1:0]   idx_q;
	logic [cpf_pkg::STEP_W-1:0]  step_q;
	logic [cpf_pkg::CNT_W-1:0]   pos_in;
	logic                        accept;
	logic                        take;
	logic                        step_done;
	logic                        advance;
	logic                        drain_end;

	// Request decode
	assign accept    = elem_valid && elem_ready;
	assign pos_in    = elem_first ? '0 : count_q;
	assign take      = accept && (pos_in < cpf_pkg::CNT_W'(cpf_pkg::MAX_ELEMENTS));
	assign step_done = (step_q == cpf_pkg::STEP_W'(cpf_pkg::GCD_STEPS));
	// head may move unless it holds a pair and the output slot stays full
	assign advance   = !head.hit || !out_busy;
	assign drain_end = (idx_q == pos_q - cpf_pkg::IDX_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cpf_pkg::ST_IDLE: begin
				if (take && pos_in != '0) begin
					state_d = cpf_pkg::ST_GCD;
				end
			end
			cpf_pkg::ST_GCD: begin
				if (step_done) begin
					state_d = cpf_pkg::ST_DRAIN;
				end
			end
			cpf_pkg::ST_DRAIN: begin
				if (advance && drain_end) begin
					state_d = cpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cpf_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		elem_ready = 1'b0;
		case (state_q)
			cpf_pkg::ST_IDLE: begin
				elem_ready = 1'b1;
				cmd.wr     = take;
				cmd.start  = take && (pos_in != '0);
			end
			cpf_pkg::ST_GCD: begin
				cmd.step  = !step_done;
				cmd.latch = step_done;
			end
			cpf_pkg::ST_DRAIN: begin
				cmd.shift = advance;
				cmd.emit  = advance && head.hit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count, position, GCD step and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			if (take) begin
				count_q <= pos_in + cpf_pkg::CNT_W'(1);
				pos_q   <= pos_in[cpf_pkg::IDX_W-1:0];
				idx_q   <= '0;
				step_q  <= '0;
			end
			if (cmd.step) begin
				step_q <= step_q + cpf_pkg::STEP_W'(1);
			end
			if (cmd.shift) begin
				idx_q <= idx_q + cpf_pkg::IDX_W'(1);
			end
		end
	end

	assign wr_pos   = pos_in[cpf_pkg::IDX_W-1:0];
	assign pair_pos = pos_q;
	assign pair_idx = idx_q;

endmodule

>>> src/coprime_pair_finder.sv
// coprime_pair_finder: top level; row of GCD cells, sequencer and output register.
// Depends on cpf_pkg, cpf_cell, cpf_ctrl.
//
//  channel | direction | handshake               | payload
//  elem    | in        | elem_valid / elem_ready | cpf_in_t  (value, first)
//  pair    | out       | pair_valid / pair_ready | cpf_out_t (earlier/new value and index, last)
//
// An element at position 0, or one offered while the table is full, is taken with no GCD
// phase; any other element at position p runs a store/load step, binary GCD steps in every
// cell at once, a latch step, then shifts of the cell row until each earlier entry reaches the head.
// Reset clears the count, the sequencer and the output register; entries need no clearing.
// A stalled pair_ready holds the row while the head cell has a pair to send.
// elem_ready is high only between elements.
module coprime_pair_finder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              elem_valid,
	output logic              elem_ready,
	input  cpf_pkg::cpf_in_t  elem,
	output logic              pair_valid,
	input  logic              pair_ready,
	output cpf_pkg::cpf_out_t pair
);

	cpf_pkg::cpf_cmd_t                cmd;
	cpf_pkg::cpf_head_t               head;
	logic [cpf_pkg::IDX_W-1:0]        wr_pos;
	logic [cpf_pkg::IDX_W-1:0]        pair_pos;
	logic [cpf_pkg::IDX_W-1:0]        pair_idx;
	logic [cpf_pkg::VALUE_BITS-1:0]   new_val;
	logic [cpf_pkg::VALUE_BITS-1:0]   new_val_q;
	logic [cpf_pkg::VALUE_BITS-1:0]   carry [cpf_pkg::MAX_ELEMENTS];
	logic [cpf_pkg::MAX_ELEMENTS-1:0] hit;
	logic                             pair_valid_q;
	cpf_pkg::cpf_out_t                pair_q;

	assign new_val = elem.value[cpf_pkg::VALUE_BITS-1:0];

	cpf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem_valid),
		.elem_first (elem.first),
		.elem_ready (elem_ready),
		.head       (head),
		.out_busy   (pair_valid_q && !pair_ready),
		.cmd        (cmd),
		.wr_pos     (wr_pos),
		.pair_pos   (pair_pos),
		.pair_idx   (pair_idx)
	);

	// Cell row; carriers move toward cell 0 during drain
	for (genvar k = 0; k < cpf_pkg::MAX_ELEMENTS; k++) begin : g_cell
		logic [cpf_pkg::VALUE_BITS-1:0] c_in;
		logic                           h_in;
		if (k == cpf_pkg::MAX_ELEMENTS - 1) begin : g_tail
			assign c_in = '0;
			assign h_in = 1'b0;
		end else begin : g_mid
			assign c_in = carry[k+1];
			assign h_in = hit[k+1];
		end
		cpf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.wr_sel   (wr_pos == cpf_pkg::IDX_W'(k)),
			.part     (cpf_pkg::IDX_W'(k) < wr_pos),
			.new_val  (new_val),
			.carry_in (c_in),
			.hit_in   (h_in),
			.carry    (carry[k]),
			.hit      (hit[k])
		);
	end

	assign head.hit  = hit[0];
	assign head.more = |(hit >> 1);

	// New element kept for the result fields
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			new_val_q <= new_val;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			pair_valid_q <= 1'b1;
		end else if (pair_ready) begin
			pair_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pair_q.earlier_value <= 8'(carry[0]);
			pair_q.earlier_index <= 6'(pair_idx);
			pair_q.new_value     <= 8'(new_val_q);
			pair_q.new_index     <= 6'(pair_pos);
			pair_q.last          <= !head.more;
		end
	end

	assign pair_valid = pair_valid_q;
	assign pair       = pair_q;

endmodule

>>> src/cpf_checker.sv
// cpf_checker: port-level checks for coprime_pair_finder, bound to the top level.
// Depends on cpf_pkg and coprime_pair_finder.
module cpf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              elem_valid,
	input logic              elem_ready,
	input cpf_pkg::cpf_in_t  elem,
	input logic              pair_valid,
	input logic              pair_ready,
	input cpf_pkg::cpf_out_t pair
);

	// A stalled result request holds
	a_pair_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && !pair_ready |=> pair_valid && $stable(pair))
		else $error("pair request changed while stalled");

	// The stored partner always sits earlier in the table
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid |-> pair.earlier_index < pair.new_index)
		else $error("earlier_index not below new_index");

	// Two even values share a factor of two
	a_not_both_even: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid |-> (pair.earlier_value[0] || pair.new_value[0]))
		else $error("pair of even values reported as coprime");

	// A new array has no partners, so the block is ready again at once
	a_first_quick: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_ready && elem.first |=> elem_ready)
		else $error("not ready after first element");

endmodule

bind coprime_pair_finder cpf_checker u_cpf_checker (.*);

>>> tb/testbench.sv
// testbench: self-checking bench for coprime_pair_finder; a typed table of element requests,
// then random arrays, each pair checked against an in-bench Euclid model of the element table.
// Depends on cpf_pkg and coprime_pair_finder.
module testbench;

	localparam int RANDOM_ELEMS = 330;
	localparam int TAIL_ELEMS   = 40;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 200;
	localparam int MAX_REPORTS  = 10;

	logic              clk;
	logic              arst_n;
	logic              elem_valid;
	logic              elem_ready;
	cpf_pkg::cpf_in_t  elem;
	logic              pair_valid;
	logic              pair_ready;
	cpf_pkg::cpf_out_t pair;

	coprime_pair_finder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem       (elem),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair       (pair)
	);

	// Directed request, optionally with its pair typed in
	typedef struct {
		cpf_pkg::cpf_in_t  req;
		bit                typed;
		int                n_pairs;
		cpf_pkg::cpf_out_t pair;
	} elem_case_t;

	localparam int N_CASES = 21;
	elem_case_t elem_cases [0:N_CASES-1] = '{
		'{'{8'd255, 1'b1}, 1'b1, 0, '0},                               // first element, no partner
		'{'{8'd1,   1'b0}, 1'b1, 1, '{8'd255, 6'd0, 8'd1, 6'd1, 1'b1}},
		'{'{8'd0,   1'b0}, 1'b1, 1, '{8'd1, 6'd1, 8'd0, 6'd2, 1'b1}},  // zero only pairs with one
		'{'{8'd0,   1'b0}, 1'b1, 1, '{8'd1, 6'd1, 8'd0, 6'd3, 1'b1}},  // zero with zero is not coprime
		'{'{8'd254, 1'b0}, 1'b0, 0, '0},
		'{'{8'd128, 1'b0}, 1'b0, 0, '0},
		'{'{8'd170, 1'b0}, 1'b0, 0, '0},
		'{'{8'd85,  1'b0}, 1'b0, 0, '0},
		'{'{8'd6,   1'b1}, 1'b1, 0, '0},                               // restart the array
		'{'{8'd4,   1'b0}, 1'b1, 0, '0},                               // no coprime partner
		'{'{8'd9,   1'b0}, 1'b1, 1, '{8'd4, 6'd1, 8'd9, 6'd2, 1'b1}},
		'{'{8'd2,   1'b0}, 1'b0, 0, '0},
		'{'{8'd1,   1'b1}, 1'b1, 0, '0},
		'{'{8'd255, 1'b0}, 1'b1, 1, '{8'd1, 6'd0, 8'd255, 6'd1, 1'b1}},
		'{'{8'd0,   1'b0}, 1'b0, 0, '0},
		'{'{8'd1,   1'b0}, 1'b0, 0, '0},
		'{'{8'd127, 1'b1}, 1'b1, 0, '0},
		'{'{8'd254, 1'b0}, 1'b1, 0, '0},                               // shares the factor 127
		'{'{8'd129, 1'b0}, 1'b0, 0, '0},
		'{'{8'd255, 1'b0}, 1'b0, 0, '0},
		'{'{8'd64,  1'b0}, 1'b0, 0, '0}
	};

	// Element table shadow and pairs still to arrive
	logic [7:0]        shadow_elems [0:cpf_pkg::MAX_ELEMENTS-1];
	int                shadow_count;
	cpf_pkg::cpf_out_t fresh_pairs [$];
	cpf_pkg::cpf_out_t awaited_pairs [$];

	int mismatches;
	bit quiet_tail;
	bit long_hold_req;
	bit sender_calm;

	// Clock and time limit
	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [7:0] euclid_gcd(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] r;
		x = a;
		y = b;
		while (y != 8'd0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Store one element in the shadow table and collect its coprime pairs in order
	function automatic bit predict_coprime_pairs(input cpf_pkg::cpf_in_t req);
		cpf_pkg::cpf_out_t p;
		int                pos;
		fresh_pairs.delete();
		if (req.first)
			shadow_count = 0;
		if (shadow_count >= cpf_pkg::MAX_ELEMENTS)
			return 1'b0;
		pos = shadow_count;
		for (int k = 0; k < pos; k++) begin
			if (euclid_gcd(shadow_elems[k], req.value) == 8'd1) begin
				p.earlier_value = shadow_elems[k];
				p.earlier_index = k[5:0];
				p.new_value     = req.value;
				p.new_index     = pos[5:0];
				p.last          = 1'b0;
				fresh_pairs.push_back(p);
			end
		end
		if (fresh_pairs.size() > 0) begin
			p = fresh_pairs[fresh_pairs.size()-1];
			p.last = 1'b1;
			fresh_pairs[fresh_pairs.size()-1] = p;
		end
		shadow_elems[pos] = req.value;
		shadow_count = pos + 1;
		return 1'b1;
	endfunction

	// Offer one element request; record its pairs once accepted, then maybe idle
	task automatic offer_elem(input cpf_pkg::cpf_in_t req, input bit typed, input int n_typed,
			input cpf_pkg::cpf_out_t typed_pair, output bit stored);
		elem       <= req;
		elem_valid <= 1'b1;
		@(posedge clk);
		while (!elem_ready)
			@(posedge clk);
		stored = predict_coprime_pairs(req);
		if (typed) begin
			if (n_typed > 0)
				awaited_pairs.push_back(typed_pair);
		end else begin
			foreach (fresh_pairs[i])
				awaited_pairs.push_back(fresh_pairs[i]);
		end
		if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0) begin
			elem_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] rand_value();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick == 0)
			return 8'd0;
		else if (pick < 10)
			return 8'($urandom_range(1, 16));
		else
			return 8'($urandom_range(1, 255));
	endfunction

	// Result side: random ready bursts, one long hold-off on request
	initial begin
		pair_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (long_hold_req) begin
				pair_ready <= 1'b0;
				long_hold_req = 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				pair_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				pair_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Check each accepted pair against the oldest awaited one
	always @(posedge clk) begin
		cpf_pkg::cpf_out_t want;
		bit                bad;
		if (arst_n && pair_valid && pair_ready) begin
			if (awaited_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected pair: ev=%0d ei=%0d nv=%0d ni=%0d last=%0b",
						pair.earlier_value, pair.earlier_index, pair.new_value,
						pair.new_index, pair.last);
			end else begin
				want = awaited_pairs.pop_front();
				bad = (pair.earlier_value !== want.earlier_value) ||
					(pair.earlier_index !== want.earlier_index) ||
					(pair.new_value !== want.new_value) ||
					(pair.new_index !== want.new_index) ||
					(pair.last !== want.last);
				if (bad) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("pair mismatch: expected ev=%0d ei=%0d nv=%0d ni=%0d last=%0b",
							want.earlier_value, want.earlier_index, want.new_value,
							want.new_index, want.last);
						$display("               got      ev=%0d ei=%0d nv=%0d ni=%0d last=%0b",
							pair.earlier_value, pair.earlier_index, pair.new_value,
							pair.new_index, pair.last);
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		cpf_pkg::cpf_in_t req;
		bit               stored;
		int               stored_total;
		int               array_no;
		int               len;
		int               pick;
		arst_n        <= 1'b0;
		elem_valid    <= 1'b0;
		elem          <= '0;
		mismatches    = 0;
		quiet_tail    = 1'b0;
		long_hold_req = 1'b0;
		sender_calm   = 1'b0;
		shadow_count  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < N_CASES; i++)
			offer_elem(elem_cases[i].req, elem_cases[i].typed, elem_cases[i].n_pairs,
				elem_cases[i].pair, stored);

		// Random arrays; the first one overfills the table
		stored_total = 0;
		array_no = 0;
		while (stored_total < RANDOM_ELEMS) begin
			if (array_no == 0) begin
				len = 68;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					len = $urandom_range(64, 72);
				else if (pick < 4)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(2, 12);
			end
			sender_calm = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < len && stored_total < RANDOM_ELEMS; j++) begin
				if (array_no == 0 && j == 40)
					long_hold_req = 1'b1;
				if (stored_total >= RANDOM_ELEMS - TAIL_ELEMS)
					quiet_tail = 1'b1;
				req.value = rand_value();
				// an occasional stray restart breaks a later array short
				req.first = (j == 0) || (array_no != 0 && $urandom_range(0, 59) == 0);
				offer_elem(req, 1'b0, 0, '0, stored);
				if (stored)
					stored_total++;
			end
			// after the fourth array, hold back new requests until every pair has come out
			if (array_no == 3) begin
				elem_valid <= 1'b0;
				wait (awaited_pairs.size() == 0);
				@(posedge clk);
			end
			array_no++;
		end

		elem_valid <= 1'b0;
		wait (awaited_pairs.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && awaited_pairs.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
src/cpf_pkg.sv
src/cpf_cell.sv
src/cpf_ctrl.sv
src/coprime_pair_finder.sv
src/cpf_checker.sv
tb/testbench.sv
